### src/wli_pkg.sv
// ----------------------------------------------------------------------------
// wli_pkg
// Shared types and constants for the windowed Lagrange interpolator.
// ----------------------------------------------------------------------------
package wli_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int ORD_W       = 4;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 11;

    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP_ORDER = 8'd1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;
    localparam logic [1:0] ST_ORDER = 2'd3;

    typedef enum logic [1:0] {
        K_WRITE,
        K_QUERY,
        K_BAD
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [9:0]         idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_item;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SRCH_RD,
        B_SRCH_CMP,
        B_NEAR_RD1,
        B_NEAR_CMP,
        B_WIN,
        B_J_RD,
        B_J_LAT,
        B_I_RD,
        B_I_CHK,
        B_I_DIV,
        B_I_MUL,
        B_I_SCL,
        B_J_MUL,
        B_J_SCL,
        B_RESULT
    } t_bstate;

endpackage

### src/wli_front.sv
// ----------------------------------------------------------------------------
// wli_front
// Configuration registers, input beat acceptance and item classification.
// ----------------------------------------------------------------------------
module wli_front #(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_ORDER   = 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [79:0]                          i_s_tdata,  // entry_index, x_value, y_value
    input  logic                                 i_s_tuser,  // op
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [wli_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [wli_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output wli_pkg::t_item                       o_item,
    output logic                                 o_item_valid,
    input  logic                                 i_item_ready,
    output logic [$clog2(TABLE_DEPTH):0]         o_n,
    output logic [wli_pkg::ORD_W-1:0]            o_ord
);
    import wli_pkg::*;

    localparam int NW = $clog2(TABLE_DEPTH) + 1;

    logic [10:0] r_point_count;
    logic [2:0]  r_interp_order;
    logic        wr_cfg;
    logic        in_range;

    assign o_cfg_ready = 1'b1;
    assign wr_cfg      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count  <= 11'd1024;
            r_interp_order <= 3'd1;
        end else if (wr_cfg) begin
            if (i_cfg_index == CFG_POINT_COUNT) begin
                r_point_count <= i_cfg_data;
            end else if (i_cfg_index == CFG_INTERP_ORDER) begin
                r_interp_order <= i_cfg_data[2:0];
            end
        end
    end

    always_comb begin
        o_n   = (32'(r_point_count) < 32'(TABLE_DEPTH)) ? NW'(r_point_count)
                                                        : NW'(TABLE_DEPTH);
        o_ord = (32'(r_interp_order) < 32'(MAX_ORDER)) ? ORD_W'(r_interp_order)
                                                       : ORD_W'(MAX_ORDER);
    end

    always_comb begin
        o_item.idx = i_s_tdata[9:0];
        o_item.x   = i_s_tdata[41:10];
        o_item.y   = i_s_tdata[73:42];
        in_range   = 32'(i_s_tdata[9:0]) < 32'(TABLE_DEPTH);
        if (i_s_tuser == OP_WRITE) begin
            o_item.kind = K_WRITE;
        end else if (32'(o_ord) >= 32'(o_n)) begin
            o_item.kind = K_BAD;
        end else begin
            o_item.kind = K_QUERY;
        end
        // out of range writes are taken and dropped
        o_item_valid = i_s_tvalid && !((i_s_tuser == OP_WRITE) && !in_range);
        o_s_tready   = i_item_ready;
    end

endmodule

### src/wli_fifo.sv
// ----------------------------------------------------------------------------
// wli_fifo
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module wli_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  wli_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output wli_pkg::t_item o_item
);
    import wli_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_item         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [PW:0]   r_cnt, n_cnt;
    logic          push, pop;

    always_comb begin
        o_ready = r_cnt != (PW+1)'(QUEUE_DEPTH);
        o_valid = r_cnt != '0;
        o_item  = r_mem[r_rp];
        push    = i_valid && o_ready;
        pop     = o_valid && i_ready;
        n_wp    = push ? PW'(r_wp + 1'b1) : r_wp;
        n_rp    = pop ? PW'(r_rp + 1'b1) : r_rp;
        n_cnt   = r_cnt + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

### src/wli_div.sv
// ----------------------------------------------------------------------------
// wli_div
// Q16.16 signed divider, two quotient bits per cycle, saturating result.
// ----------------------------------------------------------------------------
module wli_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_num,
    input  logic signed [32:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_q,
    output logic               o_sat
);
    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [47:0] r_a;
    logic [31:0] r_r;
    logic [31:0] r_b;
    logic [47:0] r_q;
    logic        r_neg;
    logic [32:0] an, bn, t1, t2;
    logic [31:0] r1, r2;
    logic        q1, q2;

    always_comb begin
        an = i_num[32] ? 33'(-i_num) : 33'(i_num);
        bn = i_den[32] ? 33'(-i_den) : 33'(i_den);
        t1 = {r_r, r_a[47]};
        q1 = t1 >= {1'b0, r_b};
        r1 = q1 ? 32'(t1 - {1'b0, r_b}) : t1[31:0];
        t2 = {r1, r_a[46]};
        q2 = t2 >= {1'b0, r_b};
        r2 = q2 ? 32'(t2 - {1'b0, r_b}) : t2[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd23;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= {an[31:0], 16'h0000};
            r_b   <= bn[31:0];
            r_r   <= '0;
            r_q   <= '0;
            r_neg <= i_num[32] ^ i_den[32];
        end else if (r_busy) begin
            r_a <= {r_a[45:0], 2'b00};
            r_r <= r2;
            r_q <= {r_q[45:0], q1, q2};
        end
    end

    always_comb begin
        o_done = r_done;
        if (r_neg) begin
            o_sat = r_q > 48'h0000_8000_0000;
            o_q   = o_sat ? 32'sh8000_0000 : 32'(-r_q);
        end else begin
            o_sat = r_q > 48'h0000_7FFF_FFFF;
            o_q   = o_sat ? 32'sh7FFF_FFFF : r_q[31:0];
        end
    end

endmodule

### src/wli_back.sv
// ----------------------------------------------------------------------------
// wli_back
// Sample table, nearest entry search, window placement and Lagrange sum.
// ----------------------------------------------------------------------------
module wli_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wli_pkg::t_item                i_item,
    input  logic                          i_item_valid,
    output logic                          o_item_ready,
    input  logic [$clog2(TABLE_DEPTH):0]  i_n,
    input  logic [wli_pkg::ORD_W-1:0]     i_ord,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [31:0]                   o_m_tdata,  // interp_value
    output logic [1:0]                    o_m_tuser   // status
);
    import wli_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = AW + 1;

    function automatic logic signed [47:0] scl(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + (v[63] ? 64'sd65535 : 64'sd0);
        return t[63:16];
    endfunction

    function automatic logic [32:0] sat48(input logic signed [47:0] v);
        logic [32:0] res;
        if (v > 48'sh0000_7FFF_FFFF) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (v < $signed(48'hFFFF_8000_0000)) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    logic [31:0] r_xmem [TABLE_DEPTH];
    logic [31:0] r_ymem [TABLE_DEPTH];

    t_bstate            r_state, n_state;
    logic signed [31:0] r_xrd, r_yrd;
    logic signed [31:0] r_x, n_x;
    logic [NW-1:0]      r_n, n_n;
    logic [ORD_W-1:0]   r_ord, n_ord;
    logic [NW-1:0]      r_lo, n_lo, r_hi, n_hi, r_mid, n_mid, r_idx, n_idx;
    logic signed [31:0] r_xa, n_xa;
    logic [AW-1:0]      r_start, n_start;
    logic [4:0]         r_i, n_i, r_j, n_j;
    logic signed [31:0] r_xj, n_xj, r_yj, n_yj, r_p, n_p, r_q, n_q, r_sum, n_sum;
    logic signed [63:0] r_prod, n_prod;
    logic               r_sat, n_sat;
    logic [1:0]         r_rst, n_rst;
    logic               r_ovalid, n_ovalid;
    logic [31:0]        r_oval, n_oval;
    logic [1:0]         r_ostat, n_ostat;

    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW+9:0]      wr_ext;
    logic [NW-1:0]      mid_c;
    logic signed [32:0] da, db, s33;
    logic [32:0]        ma, mb;
    logic [NW+1:0]      two_idx, two_nm1, ord_e;
    logic [32:0]        sv, sv2;
    logic               div_start, div_done, div_sat;
    logic signed [31:0] div_q;
    logic signed [32:0] div_num, div_den;

    wli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_q     (div_q),
        .o_sat   (div_sat)
    );

    assign wr_ext = {{AW{1'b0}}, i_item.idx};
    assign wr_en  = (r_state == B_IDLE) && i_item_valid && (i_item.kind == K_WRITE);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_xmem[wr_ext[AW-1:0]] <= i_item.x;
            r_ymem[wr_ext[AW-1:0]] <= i_item.y;
        end
        r_xrd <= r_xmem[rd_addr];
        r_yrd <= r_ymem[rd_addr];
    end

    always_comb begin
        mid_c   = r_lo + ((r_hi - r_lo) >> 1);
        da      = {r_x[31], r_x} - {r_xa[31], r_xa};
        db      = {r_x[31], r_x} - {r_xrd[31], r_xrd};
        ma      = da[32] ? 33'(-da) : 33'(da);
        mb      = db[32] ? 33'(-db) : 33'(db);
        two_idx = {1'b0, r_idx, 1'b0};
        two_nm1 = {1'b0, NW'(r_n - 1'b1), 1'b0};
        ord_e   = (NW+2)'(r_ord);
        div_num = {r_x[31], r_x} - {r_xrd[31], r_xrd};
        div_den = {r_xj[31], r_xj} - {r_xrd[31], r_xrd};
        sv      = sat48(scl(r_prod));
        s33     = {r_sum[31], r_sum} + {sv[31], sv[31:0]};
        sv2     = sat48(48'(s33));
    end

    always_comb begin
        n_state = r_state;   n_x = r_x;       n_n = r_n;       n_ord = r_ord;
        n_lo = r_lo;         n_hi = r_hi;     n_mid = r_mid;   n_idx = r_idx;
        n_xa = r_xa;         n_start = r_start;
        n_i = r_i;           n_j = r_j;       n_xj = r_xj;     n_yj = r_yj;
        n_p = r_p;           n_q = r_q;       n_sum = r_sum;   n_prod = r_prod;
        n_sat = r_sat;       n_rst = r_rst;
        n_ovalid = r_ovalid && !i_m_tready;
        n_oval = r_oval;     n_ostat = r_ostat;
        rd_addr = '0;
        div_start = 1'b0;
        o_item_ready = 1'b0;
        case (r_state)
            B_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    case (i_item.kind)
                        K_QUERY: begin
                            n_x = i_item.x;
                            n_n = i_n;
                            n_ord = i_ord;
                            n_lo = '0;
                            n_hi = i_n;
                            n_sum = '0;
                            n_sat = 1'b0;
                            n_j = '0;
                            n_state = B_SRCH_RD;
                        end
                        K_BAD: begin
                            n_sum = '0;
                            n_rst = ST_ORDER;
                            n_state = B_RESULT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            B_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    rd_addr = mid_c[AW-1:0];
                    n_mid = mid_c;
                    n_state = B_SRCH_CMP;
                end else if (r_lo == '0) begin
                    n_idx = '0;
                    n_state = B_WIN;
                end else if (r_lo >= r_n) begin
                    n_idx = NW'(r_n - 1'b1);
                    n_state = B_WIN;
                end else begin
                    rd_addr = AW'(r_lo - 1'b1);
                    n_state = B_NEAR_RD1;
                end
            end
            B_SRCH_CMP: begin
                if (r_xrd < r_x) begin
                    n_lo = NW'(r_mid + 1'b1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = B_SRCH_RD;
            end
            B_NEAR_RD1: begin
                n_xa = r_xrd;
                rd_addr = r_lo[AW-1:0];
                n_state = B_NEAR_CMP;
            end
            B_NEAR_CMP: begin
                n_idx = (ma < mb) ? NW'(r_lo - 1'b1) : r_lo;
                n_state = B_WIN;
            end
            B_WIN: begin
                if (two_idx <= ord_e) begin
                    n_start = '0;
                end else if ((two_nm1 - ord_e) <= two_idx) begin
                    n_start = AW'(32'(r_n) - 32'd1 - 32'(r_ord));
                end else begin
                    n_start = AW'(32'(r_idx) - ((32'(r_ord) + 32'd1) >> 1));
                end
                n_state = B_J_RD;
            end
            B_J_RD: begin
                rd_addr = AW'(32'(r_start) + 32'(r_j));
                n_state = B_J_LAT;
            end
            B_J_LAT: begin
                n_xj = r_xrd;
                n_yj = r_yrd;
                n_p = Q_ONE;
                n_i = '0;
                n_state = B_I_RD;
            end
            B_I_RD: begin
                if (r_i > {1'b0, r_ord}) begin
                    n_state = B_J_MUL;
                end else if (r_i == r_j) begin
                    n_i = r_i + 1'b1;
                end else begin
                    rd_addr = AW'(32'(r_start) + 32'(r_i));
                    n_state = B_I_CHK;
                end
            end
            B_I_CHK: begin
                if (r_xrd == r_xj) begin
                    n_sum = '0;
                    n_rst = ST_DUP;
                    n_state = B_RESULT;
                end else begin
                    div_start = 1'b1;
                    n_state = B_I_DIV;
                end
            end
            B_I_DIV: begin
                if (div_done) begin
                    n_q = div_q;
                    n_sat = r_sat | div_sat;
                    n_state = B_I_MUL;
                end
            end
            B_I_MUL: begin
                n_prod = r_p * r_q;
                n_state = B_I_SCL;
            end
            B_I_SCL: begin
                n_p = sv[31:0];
                n_sat = r_sat | sv[32];
                n_i = r_i + 1'b1;
                n_state = B_I_RD;
            end
            B_J_MUL: begin
                n_prod = r_yj * r_p;
                n_state = B_J_SCL;
            end
            B_J_SCL: begin
                n_sum = sv2[31:0];
                n_sat = r_sat | sv[32] | sv2[32];
                if (r_j == {1'b0, r_ord}) begin
                    n_rst = (r_sat | sv[32] | sv2[32]) ? ST_SAT : ST_OK;
                    n_state = B_RESULT;
                end else begin
                    n_j = r_j + 1'b1;
                    n_state = B_J_RD;
                end
            end
            B_RESULT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_oval = r_sum;
                    n_ostat = r_rst;
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;         r_n <= n_n;       r_ord <= n_ord;
        r_lo <= n_lo;       r_hi <= n_hi;     r_mid <= n_mid;   r_idx <= n_idx;
        r_xa <= n_xa;       r_start <= n_start;
        r_i <= n_i;         r_j <= n_j;       r_xj <= n_xj;     r_yj <= n_yj;
        r_p <= n_p;         r_q <= n_q;       r_sum <= n_sum;   r_prod <= n_prod;
        r_sat <= n_sat;     r_rst <= n_rst;
        r_oval <= n_oval;   r_ostat <= n_ostat;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_oval;
    assign o_m_tuser  = r_ostat;

    a_search_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SRCH_CMP) |-> ((r_lo < r_hi) && (r_hi <= r_n)))
        else $error("search interval out of bounds");

    a_window_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_J_RD) |-> ((32'(r_start) + 32'(r_ord)) < 32'(r_n)))
        else $error("window runs past table end");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && ((r_ostat == ST_DUP) || (r_ostat == ST_ORDER))) |-> (r_oval == '0))
        else $error("error result carries nonzero value");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_state == B_I_DIV))
        else $error("divider started outside divide step");

endmodule

### src/windowed_lagrange_interpolator.sv
// ----------------------------------------------------------------------------
// windowed_lagrange_interpolator
// Piecewise Lagrange interpolation over a written Q16.16 sample table.
// ----------------------------------------------------------------------------
// A write beat (op 0) stores one abscissa/ordinate pair and gives no result; the
// back end stores it while idle. A query beat (op 1) gives one result: the
// nearest entry is found by a binary search over the table memory (each probe
// a read, then a compare), then a window of order+1 points is evaluated with
// one shared divider (two quotient bits a cycle) and 32x32 multiplies into one
// shared product register. For each window point, a quotient against every
// other window point is divided out, multiplied into the point's weight and
// scaled; the weight times the point's ordinate is then added to the sum.
// A four-entry queue lets input beats be taken while a query is in progress,
// and a result register lets the next item start while a result waits.
// The table memories need no clearing after reset; reading an entry never
// written gives an undefined value.
module windowed_lagrange_interpolator #(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_ORDER   = 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [79:0]                          s_axis_tdata,  // entry_index, x_value, y_value
    input  logic                                 s_axis_tuser,  // op
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [31:0]                          m_axis_tdata,  // interp_value
    output logic [1:0]                           m_axis_tuser,  // status
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [wli_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [wli_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import wli_pkg::*;

    localparam int NW = $clog2(TABLE_DEPTH) + 1;

    t_item             f_item, q_item;
    logic              f_valid, f_ready, q_valid, q_ready;
    logic [NW-1:0]     cfg_n;
    logic [ORD_W-1:0]  cfg_ord;

    wli_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_ORDER   (MAX_ORDER)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .o_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_item       (f_item),
        .o_item_valid (f_valid),
        .i_item_ready (f_ready),
        .o_n          (cfg_n),
        .o_ord        (cfg_ord)
    );

    wli_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    wli_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_n          (cfg_n),
        .i_ord        (cfg_ord),
        .o_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_m_tdata    (m_axis_tdata),
        .o_m_tuser    (m_axis_tuser)
    );

endmodule
